### hw/rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants for the framed packet receiver
// Result layout, configuration set, store write request and phase codes.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // Deframer phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_PAY  = 3'd2;
  localparam logic [2:0] PH_CHK  = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  // Reply kinds
  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NAK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_ACK   = 2'd2;
  localparam logic [1:0] CFG_NAK   = 2'd3;

  // Configuration reset values
  localparam logic [7:0] START_RST = 8'd2;
  localparam logic [7:0] END_RST   = 8'd3;
  localparam logic [7:0] ACK_RST   = 8'd6;
  localparam logic [7:0] NAK_RST   = 8'd21;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] ack_byte;
    logic [7:0] nak_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic [7:0] reply_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       packet_done;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } store_wr_t;

endpackage

### hw/rtl/fpr_in_if.sv
// ----------------------------------------------------------------------------
// fpr_in_if: received byte channel
// Valid/ready channel carrying one link byte per transaction.
// ----------------------------------------------------------------------------
interface fpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/fpr_out_if.sv
// ----------------------------------------------------------------------------
// fpr_out_if: receiver result channel
// Valid/ready channel carrying reply, payload echo and completion flag.
// ----------------------------------------------------------------------------
interface fpr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [7:0] reply_byte;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       packet_done;

  modport source (output valid, output reply_kind, output reply_byte,
                  output payload_valid, output payload_byte,
                  output payload_index, output packet_done, input ready);
  modport sink   (input valid, input reply_kind, input reply_byte,
                  input payload_valid, input payload_byte,
                  input payload_index, input packet_done, output ready);
endinterface

### hw/rtl/fpr_deframer.sv
// ----------------------------------------------------------------------------
// fpr_deframer: packet framing state machine
// Tracks phase, length, position and checksum; builds one result per byte.
// ----------------------------------------------------------------------------
module fpr_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  fpr_pkg::cfg_t      cfg,
  output fpr_pkg::result_t   result,
  output fpr_pkg::store_wr_t store_wr
);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] rx_check_r, rx_check_nxt;
  logic       done_r, done_nxt;
  logic [7:0] pos_inc;

  assign pos_inc = pos_r + 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    check_nxt    = check_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    rx_check_nxt = rx_check_r;
    done_nxt     = done_r;
    result       = '0;
    store_wr     = '0;
    unique case (phase_r)
      fpr_pkg::PH_LEN: begin
        len_nxt   = rx_byte;
        check_nxt = check_r ^ rx_byte;
        pos_nxt   = 8'd0;
        phase_nxt = (rx_byte != 8'd0) ? fpr_pkg::PH_PAY : fpr_pkg::PH_CHK;
      end
      fpr_pkg::PH_PAY: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = pos_r;
        store_wr.en   = 1'b1;
        store_wr.addr = pos_r;
        store_wr.data = rx_byte;
        check_nxt = check_r ^ rx_byte;
        pos_nxt   = pos_inc;
        if (pos_inc == len_r) begin
          phase_nxt = fpr_pkg::PH_CHK;
        end
      end
      fpr_pkg::PH_CHK: begin
        rx_check_nxt = rx_byte;
        phase_nxt    = fpr_pkg::PH_END;
      end
      fpr_pkg::PH_END: begin
        if (rx_byte == cfg.end_byte) begin
          if (rx_check_r == check_r) begin
            done_nxt          = 1'b1;
            result.reply_kind = fpr_pkg::REPLY_ACK;
            result.reply_byte = cfg.ack_byte;
          end else begin
            result.reply_kind = fpr_pkg::REPLY_NAK;
            result.reply_byte = cfg.nak_byte;
          end
        end
        phase_nxt = fpr_pkg::PH_IDLE;
      end
      default: begin
        // unused phase codes behave as idle
        if (rx_byte == cfg.start_byte) begin
          check_nxt = cfg.start_byte;
          phase_nxt = fpr_pkg::PH_LEN;
        end else begin
          phase_nxt = fpr_pkg::PH_IDLE;
        end
      end
    endcase
    result.packet_done = done_nxt;
    store_wr.en = store_wr.en & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fpr_pkg::PH_IDLE;
      check_r    <= 8'd0;
      len_r      <= 8'd0;
      pos_r      <= 8'd0;
      rx_check_r <= 8'd0;
      done_r     <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      check_r    <= check_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      rx_check_r <= rx_check_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

### hw/rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver: start/end framed packet receiver with XOR checksum
// Each result is registered in the output register, or in the skid entry
// while the sink stalls. Throughput: one byte per cycle while the skid entry
// is free; a two-entry output stage keeps input open while one result waits.
// Reset: synchronous, active low; clears framing state, sticky flag and output
// stage, loads marker defaults. The payload store is not cleared.
// ----------------------------------------------------------------------------
module framed_packet_receiver #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  fpr_in_if.sink        in_rx,
  fpr_out_if.source     out_res,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [7:0]    cfg_data
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  fpr_pkg::cfg_t      cfg_r;
  fpr_pkg::result_t   result;
  fpr_pkg::store_wr_t store_wr;
  fpr_pkg::result_t   out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               accept, out_fire;
  logic [7:0]         store_mem [PAYLOAD_DEPTH];

  assign in_rx.ready = !skid_valid_r;
  assign accept      = in_rx.valid && in_rx.ready;
  assign out_fire    = out_valid_r && out_res.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= fpr_pkg::START_RST;
      cfg_r.end_byte   <= fpr_pkg::END_RST;
      cfg_r.ack_byte   <= fpr_pkg::ACK_RST;
      cfg_r.nak_byte   <= fpr_pkg::NAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fpr_pkg::CFG_START: cfg_r.start_byte <= cfg_data;
        fpr_pkg::CFG_END:   cfg_r.end_byte   <= cfg_data;
        fpr_pkg::CFG_ACK:   cfg_r.ack_byte   <= cfg_data;
        fpr_pkg::CFG_NAK:   cfg_r.nak_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  fpr_deframer u_deframer (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_rx.rx_byte),
    .cfg      (cfg_r),
    .result   (result),
    .store_wr (store_wr)
  );

  // drop payload bytes beyond the store
  always_ff @(posedge clk) begin
    if (store_wr.en && ({1'b0, store_wr.addr} < 9'(PAYLOAD_DEPTH))) begin
      store_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : result;
    end else if (accept) begin
      skid_r <= result;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.reply_kind    = out_r.reply_kind;
  assign out_res.reply_byte    = out_r.reply_byte;
  assign out_res.payload_valid = out_r.payload_valid;
  assign out_res.payload_byte  = out_r.payload_byte;
  assign out_res.payload_index = out_r.payload_index;
  assign out_res.packet_done   = out_r.packet_done;

endmodule
